FILE: rtl/sgcp_pkg.sv
// sgcp_pkg: shared types, codes and widths for the scatter-gather copy planner
// depends on nothing; used by every module under rtl
`default_nettype none

package sgcp_pkg;

  // field widths
  localparam int ADDR_BITS = 48;
  localparam int LEN_BITS  = 24;
  localparam int CNT_BITS  = 32;

  // command codes on the input transaction
  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_SRC   = 2'd1;
  localparam logic [1:0] CMD_DST   = 2'd2;

  // next-wanted codes on the result transaction
  localparam logic [1:0] NEED_SRC  = 2'd0;
  localparam logic [1:0] NEED_DST  = 2'd1;
  localparam logic [1:0] NEED_NONE = 2'd2;

  // status codes
  localparam logic ST_OK    = 1'b0;
  localparam logic ST_UNEXP = 1'b1;

  // transfer phase; the unused code reads as idle
  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_SRC  = 2'd1,
    PH_DST  = 2'd2
  } phase_t;

  // one input transaction
  typedef struct packed {
    logic [1:0]           cmd;
    logic [CNT_BITS-1:0]  start_offset;
    logic [CNT_BITS-1:0]  total_count;
    logic [ADDR_BITS-1:0] desc_addr;
    logic [LEN_BITS-1:0]  desc_length;
    logic                 desc_last;
  } item_t;

  // planner state carried from one transaction to the next
  typedef struct packed {
    phase_t               phase;
    logic [CNT_BITS-1:0]  skip_offset;
    logic [CNT_BITS-1:0]  bytes_left;
    logic [CNT_BITS-1:0]  copied_sum;
    logic [ADDR_BITS-1:0] src_addr;
    logic [LEN_BITS-1:0]  src_rem;
    logic                 src_last;
    logic [ADDR_BITS-1:0] dst_addr;
    logic [LEN_BITS-1:0]  dst_rem;
    logic                 dst_last;
  } state_t;

  // one result transaction
  typedef struct packed {
    logic                 seg_valid;
    logic [ADDR_BITS-1:0] seg_src_addr;
    logic [ADDR_BITS-1:0] seg_dst_addr;
    logic [LEN_BITS-1:0]  seg_length;
    logic [1:0]           need;
    logic                 done_res;
    logic [CNT_BITS-1:0]  copied_total;
    logic                 status;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/scatter_gather_copy_planner.sv
// Scatter-gather copy planner: one result transaction for every input transaction,
// one transaction per cycle sustained while out_ready is high; each passes the input
// register, then the result register. The per-transaction work (skip test, three-way
// minimum, address and count adds) sits between those two registers, and the planner
// state register closes its loop there, so transactions stall only on out_ready. A start
// transaction sets the source offset and byte count; the planner then asks for source
// or destination descriptors through out_need and emits at most one copy segment per
// descriptor. Descriptors that arrive unasked come back with out_status set and leave
// the state alone. Depends on sgcp_pkg, sgcp_in_reg and sgcp_step.
`default_nettype none

module scatter_gather_copy_planner (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // input channel
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [1:0]                     in_cmd,
  input  wire logic [sgcp_pkg::CNT_BITS-1:0]  in_start_offset,
  input  wire logic [sgcp_pkg::CNT_BITS-1:0]  in_total_count,
  input  wire logic [sgcp_pkg::ADDR_BITS-1:0] in_desc_addr,
  input  wire logic [sgcp_pkg::LEN_BITS-1:0]  in_desc_length,
  input  wire logic                           in_desc_last,
  // result channel
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic                                out_seg_valid,
  output logic [sgcp_pkg::ADDR_BITS-1:0]      out_seg_src_addr,
  output logic [sgcp_pkg::ADDR_BITS-1:0]      out_seg_dst_addr,
  output logic [sgcp_pkg::LEN_BITS-1:0]       out_seg_length,
  output logic [1:0]                          out_need,
  output logic                                out_done_res,
  output logic [sgcp_pkg::CNT_BITS-1:0]       out_copied_total,
  output logic                                out_status
);

  sgcp_pkg::item_t   item_in;
  sgcp_pkg::item_t   item_q;
  logic              item_vld;
  logic              take;
  sgcp_pkg::state_t  state_r;
  sgcp_pkg::state_t  state_nxt;
  sgcp_pkg::result_t res_nxt;
  sgcp_pkg::result_t res_r;
  logic              out_vld_r;

  // pack the input ports
  always_comb begin
    item_in.cmd          = in_cmd;
    item_in.start_offset = in_start_offset;
    item_in.total_count  = in_total_count;
    item_in.desc_addr    = in_desc_addr;
    item_in.desc_length  = in_desc_length;
    item_in.desc_last    = in_desc_last;
  end

  // a held transaction moves on when the result register is free or draining
  assign take = item_vld && (!out_vld_r || out_ready);

  sgcp_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .item_i   (item_in),
    .take     (take),
    .vld_o    (item_vld),
    .item_o   (item_q)
  );

  sgcp_step u_step (
    .item   (item_q),
    .st     (state_r),
    .st_nxt (state_nxt),
    .res    (res_nxt)
  );

  // planner state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (take) begin
      state_r <= state_nxt;
    end
  end

  // result register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (!out_vld_r || out_ready) begin
      out_vld_r <= take;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (take) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_seg_valid    = res_r.seg_valid;
  assign out_seg_src_addr = res_r.seg_src_addr;
  assign out_seg_dst_addr = res_r.seg_dst_addr;
  assign out_seg_length   = res_r.seg_length;
  assign out_need         = res_r.need;
  assign out_done_res     = res_r.done_res;
  assign out_copied_total = res_r.copied_total;
  assign out_status       = res_r.status;

  // a segment never has zero length
  a_seg_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_seg_valid |-> out_seg_length != '0)
    else $error("segment with zero length");

  // done flag agrees with the need code
  a_done_need: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_done_res == (out_need == sgcp_pkg::NEED_NONE)))
    else $error("done flag and need code disagree");

  // an unexpected transaction carries no segment
  a_unexp_noseg: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == sgcp_pkg::ST_UNEXP |-> !out_seg_valid)
    else $error("segment emitted on unexpected transaction");

  // state only changes when a transaction moves through the step logic
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !take |=> $stable(state_r))
    else $error("planner state changed without a transaction");

endmodule

`default_nettype wire

FILE: rtl/sgcp_in_reg.sv
// sgcp_in_reg: input register stage with valid/ready handshake
// depends on sgcp_pkg for the transaction type
`default_nettype none

module sgcp_in_reg (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire sgcp_pkg::item_t item_i,
  input  wire logic            take,
  output logic                 vld_o,
  output sgcp_pkg::item_t      item_o
);

  logic            vld_r;
  sgcp_pkg::item_t item_r;

  // accept when empty or when the held transaction moves on this cycle
  assign in_ready = !vld_r || take;
  assign vld_o    = vld_r;
  assign item_o   = item_r;

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ready) begin
      vld_r <= in_valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= item_i;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/sgcp_step.sv
// sgcp_step: next-state and result logic for one transaction
// depends on sgcp_pkg for types, widths and codes
`default_nettype none

module sgcp_step (
  input  wire sgcp_pkg::item_t  item,
  input  wire sgcp_pkg::state_t st,
  output sgcp_pkg::state_t      st_nxt,
  output sgcp_pkg::result_t     res
);

  // pick the next phase once the transaction has been absorbed
  function automatic sgcp_pkg::phase_t settle(input sgcp_pkg::state_t s);
    sgcp_pkg::phase_t p;
    if (s.bytes_left == '0) begin
      p = sgcp_pkg::PH_IDLE;
    end else if (s.src_rem == '0) begin
      p = s.src_last ? sgcp_pkg::PH_IDLE : sgcp_pkg::PH_SRC;
    end else if (s.dst_rem == '0) begin
      p = s.dst_last ? sgcp_pkg::PH_IDLE : sgcp_pkg::PH_DST;
    end else begin
      p = sgcp_pkg::PH_IDLE;
    end
    return p;
  endfunction

  always_comb begin
    sgcp_pkg::state_t                s;
    logic                            ok;
    logic [sgcp_pkg::CNT_BITS-1:0]   len_ext;
    logic [sgcp_pkg::LEN_BITS-1:0]   m_sd;
    logic [sgcp_pkg::LEN_BITS-1:0]   n;

    s       = st;
    ok      = 1'b1;
    len_ext = sgcp_pkg::CNT_BITS'(item.desc_length);
    m_sd    = '0;
    n       = '0;
    res     = '0;

    // absorb the transaction
    unique case (item.cmd)
      sgcp_pkg::CMD_START: begin
        s             = '0;
        s.skip_offset = item.start_offset;
        s.bytes_left  = item.total_count;
        s.phase       = (item.total_count == '0) ? sgcp_pkg::PH_IDLE : sgcp_pkg::PH_SRC;
      end
      sgcp_pkg::CMD_SRC: begin
        if (st.phase == sgcp_pkg::PH_SRC) begin
          if (st.skip_offset >= len_ext) begin
            // whole descriptor lies before the offset
            s.skip_offset = st.skip_offset - len_ext;
            s.src_rem     = '0;
          end else begin
            s.src_addr    = item.desc_addr + sgcp_pkg::ADDR_BITS'(st.skip_offset);
            s.src_rem     = sgcp_pkg::LEN_BITS'(len_ext - st.skip_offset);
            s.skip_offset = '0;
          end
          s.src_last = item.desc_last;
        end else begin
          ok = 1'b0;
        end
      end
      sgcp_pkg::CMD_DST: begin
        if (st.phase == sgcp_pkg::PH_DST) begin
          s.dst_addr = item.desc_addr;
          s.dst_rem  = item.desc_length;
          s.dst_last = item.desc_last;
        end else begin
          ok = 1'b0;
        end
      end
      default: begin
        ok = 1'b0;
      end
    endcase

    // emit at most one segment and settle the phase
    if (item.cmd != sgcp_pkg::CMD_START && ok) begin
      if (s.src_rem != '0 && s.dst_rem != '0 && s.bytes_left != '0) begin
        m_sd = (s.src_rem <= s.dst_rem) ? s.src_rem : s.dst_rem;
        n    = (sgcp_pkg::CNT_BITS'(m_sd) <= s.bytes_left) ?
               m_sd : sgcp_pkg::LEN_BITS'(s.bytes_left);
        res.seg_valid    = 1'b1;
        res.seg_src_addr = s.src_addr;
        res.seg_dst_addr = s.dst_addr;
        res.seg_length   = n;
        s.src_addr   = s.src_addr + sgcp_pkg::ADDR_BITS'(n);
        s.src_rem    = s.src_rem - n;
        s.dst_addr   = s.dst_addr + sgcp_pkg::ADDR_BITS'(n);
        s.dst_rem    = s.dst_rem - n;
        s.bytes_left = s.bytes_left - sgcp_pkg::CNT_BITS'(n);
        s.copied_sum = s.copied_sum + sgcp_pkg::CNT_BITS'(n);
      end
      s.phase = settle(s);
    end

    // report fields
    unique case (s.phase)
      sgcp_pkg::PH_SRC: begin
        res.need     = sgcp_pkg::NEED_SRC;
        res.done_res = 1'b0;
      end
      sgcp_pkg::PH_DST: begin
        res.need     = sgcp_pkg::NEED_DST;
        res.done_res = 1'b0;
      end
      default: begin
        res.need     = sgcp_pkg::NEED_NONE;
        res.done_res = 1'b1;
      end
    endcase
    res.copied_total = s.copied_sum;
    res.status       = ok ? sgcp_pkg::ST_OK : sgcp_pkg::ST_UNEXP;

    st_nxt = s;
  end

endmodule

`default_nettype wire
